// ===== design/ise_pkg.sv =====
// Shared types, sizes and codes for the indexed stack engine.
// Used by ise_ctrl, ise_dp and indexed_stack_engine; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int FIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 4'd0,
        CMD_POP        = 4'd1,
        CMD_POP_BOTTOM = 4'd2,
        CMD_PEEK       = 4'd3,
        CMD_GET        = 4'd4,
        CMD_SET        = 4'd5,
        CMD_FIND       = 4'd6,
        CMD_SWAP       = 4'd7,
        CMD_REMOVE_AT  = 4'd8,
        CMD_CLEAR      = 4'd9
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_FIND_RD,
        S_FIND_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SWAP_RD_B,
        S_SWAP_WR_A,
        S_SWAP_WR_B,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        RD_TOP,
        RD_PA,
        RD_PB,
        RD_PTR,
        RD_PTR1,
        RD_ZERO
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_COUNT,
        WR_PA,
        WR_PB,
        WR_PTR
    } t_wr_sel;

    typedef enum logic [1:0] {
        WD_VAL,
        WD_RD,
        WD_HOLD
    } t_wd_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_PA,
        PTR_INC
    } t_ptr_op;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_wd_sel wd_sel;
        logic    hold_we;
        t_cnt_op cnt_op;
        t_ptr_op ptr_op;
        logic    res_status_we;
        t_status res_status;
        logic    res_data_we;
        logic    res_fidx_we;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic pa_ok;
        logic pb_ok;
        logic ptr_lt_cnt;
        logic ptr1_lt_cnt;
        logic match;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/ise_ctrl.sv =====
// Command sequencer of the indexed stack engine: one state machine that
// steps the datapath through each command. Depends on ise_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ise_pkg::t_dp_sts i_sts,
    output ise_pkg::t_dp_cmd     o_cmd
);

    ise_pkg::t_state r_state;
    ise_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ise_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ise_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ise_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ise_pkg::S_DISPATCH;
            end
            ise_pkg::S_DISPATCH: begin
                case (i_sts.cmd)
                    ise_pkg::CMD_POP, ise_pkg::CMD_PEEK, ise_pkg::CMD_POP_BOTTOM: begin
                        n_state = i_sts.empty ? ise_pkg::S_RESP : ise_pkg::S_RD_WAIT;
                    end
                    ise_pkg::CMD_GET: begin
                        n_state = i_sts.pa_ok ? ise_pkg::S_RD_WAIT : ise_pkg::S_RESP;
                    end
                    ise_pkg::CMD_FIND: begin
                        n_state = ise_pkg::S_FIND_RD;
                    end
                    ise_pkg::CMD_SWAP: begin
                        n_state = (i_sts.pa_ok && i_sts.pb_ok) ? ise_pkg::S_SWAP_RD_B
                                                               : ise_pkg::S_RESP;
                    end
                    ise_pkg::CMD_REMOVE_AT: begin
                        n_state = i_sts.pa_ok ? ise_pkg::S_SHIFT_RD : ise_pkg::S_RESP;
                    end
                    default: begin
                        n_state = ise_pkg::S_RESP;
                    end
                endcase
            end
            ise_pkg::S_RD_WAIT: begin
                n_state = (i_sts.cmd == ise_pkg::CMD_POP_BOTTOM) ? ise_pkg::S_SHIFT_RD
                                                                 : ise_pkg::S_RESP;
            end
            ise_pkg::S_SHIFT_RD: begin
                n_state = i_sts.ptr1_lt_cnt ? ise_pkg::S_SHIFT_WR : ise_pkg::S_RESP;
            end
            ise_pkg::S_SHIFT_WR: begin
                n_state = ise_pkg::S_SHIFT_RD;
            end
            ise_pkg::S_FIND_RD: begin
                n_state = i_sts.ptr_lt_cnt ? ise_pkg::S_FIND_CMP : ise_pkg::S_RESP;
            end
            ise_pkg::S_FIND_CMP: begin
                n_state = i_sts.match ? ise_pkg::S_RESP : ise_pkg::S_FIND_RD;
            end
            ise_pkg::S_SWAP_RD_B: begin
                n_state = ise_pkg::S_SWAP_WR_A;
            end
            ise_pkg::S_SWAP_WR_A: begin
                n_state = ise_pkg::S_SWAP_WR_B;
            end
            ise_pkg::S_SWAP_WR_B: begin
                n_state = ise_pkg::S_RESP;
            end
            ise_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = ise_pkg::S_IDLE;
            end
            default: begin
                n_state = ise_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ise_pkg::S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            ise_pkg::S_DISPATCH: begin
                case (i_sts.cmd)
                    ise_pkg::CMD_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = ise_pkg::WR_COUNT;
                            o_cmd.wd_sel = ise_pkg::WD_VAL;
                            o_cmd.cnt_op = ise_pkg::CNT_INC;
                        end
                    end
                    ise_pkg::CMD_POP, ise_pkg::CMD_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ise_pkg::RD_TOP;
                        end
                    end
                    ise_pkg::CMD_POP_BOTTOM: begin
                        if (i_sts.empty) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ise_pkg::RD_ZERO;
                        end
                    end
                    ise_pkg::CMD_GET: begin
                        if (!i_sts.pa_ok) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ise_pkg::RD_PA;
                        end
                    end
                    ise_pkg::CMD_SET: begin
                        if (!i_sts.pa_ok) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = ise_pkg::WR_PA;
                            o_cmd.wd_sel = ise_pkg::WD_VAL;
                        end
                    end
                    ise_pkg::CMD_FIND: begin
                        o_cmd.ptr_op = ise_pkg::PTR_ZERO;
                    end
                    ise_pkg::CMD_SWAP: begin
                        if (!(i_sts.pa_ok && i_sts.pb_ok)) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ise_pkg::RD_PA;
                        end
                    end
                    ise_pkg::CMD_REMOVE_AT: begin
                        if (!i_sts.pa_ok) begin
                            o_cmd.res_status_we = 1'b1;
                            o_cmd.res_status    = ise_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.ptr_op = ise_pkg::PTR_PA;
                        end
                    end
                    ise_pkg::CMD_CLEAR: begin
                        o_cmd.cnt_op = ise_pkg::CNT_CLR;
                    end
                    default: begin
                        o_cmd.cnt_op = ise_pkg::CNT_HOLD;
                    end
                endcase
            end
            ise_pkg::S_RD_WAIT: begin
                o_cmd.res_data_we = 1'b1;
                if (i_sts.cmd == ise_pkg::CMD_POP) o_cmd.cnt_op = ise_pkg::CNT_DEC;
                if (i_sts.cmd == ise_pkg::CMD_POP_BOTTOM) o_cmd.ptr_op = ise_pkg::PTR_ZERO;
            end
            ise_pkg::S_SHIFT_RD: begin
                if (i_sts.ptr1_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ise_pkg::RD_PTR1;
                end else begin
                    o_cmd.cnt_op = ise_pkg::CNT_DEC;
                end
            end
            ise_pkg::S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ise_pkg::WR_PTR;
                o_cmd.wd_sel = ise_pkg::WD_RD;
                o_cmd.ptr_op = ise_pkg::PTR_INC;
            end
            ise_pkg::S_FIND_RD: begin
                if (i_sts.ptr_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ise_pkg::RD_PTR;
                end else begin
                    o_cmd.res_status_we = 1'b1;
                    o_cmd.res_status    = ise_pkg::ST_NOT_FOUND;
                end
            end
            ise_pkg::S_FIND_CMP: begin
                if (i_sts.match) begin
                    o_cmd.res_fidx_we = 1'b1;
                end else begin
                    o_cmd.ptr_op = ise_pkg::PTR_INC;
                end
            end
            ise_pkg::S_SWAP_RD_B: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = ise_pkg::RD_PB;
                o_cmd.hold_we = 1'b1;
            end
            ise_pkg::S_SWAP_WR_A: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ise_pkg::WR_PA;
                o_cmd.wd_sel = ise_pkg::WD_RD;
            end
            ise_pkg::S_SWAP_WR_B: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ise_pkg::WR_PB;
                o_cmd.wd_sel = ise_pkg::WD_HOLD;
            end
            ise_pkg::S_RESP: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.load_in = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ise_dp.sv =====
// Datapath of the indexed stack engine: entry memory, count, scan pointer,
// latched item, result and output registers. Depends on ise_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [ise_pkg::CMD_W-1:0]            i_command,
    input  wire logic signed [ise_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [ise_pkg::POS_W-1:0]            i_position,
    input  wire logic [ise_pkg::POS_W-1:0]            i_position_b,
    input  wire logic                                 i_out_stall,
    output logic                                      o_out_valid,
    output logic signed [ise_pkg::VALUE_W-1:0]        o_data,
    output logic [ise_pkg::FIDX_W-1:0]                o_found_index,
    output logic [ise_pkg::STATUS_W-1:0]              o_status,
    output logic [ise_pkg::FILL_W-1:0]                o_fill_count,
    input  wire ise_pkg::t_dp_cmd                     i_cmd,
    output ise_pkg::t_dp_sts                          o_sts
);

    ise_pkg::t_word                   r_mem [ise_pkg::DEPTH];
    ise_pkg::t_word                   r_rd;
    ise_pkg::t_word                   r_hold;
    ise_pkg::t_word                   r_val;
    logic [ise_pkg::CMD_W-1:0]        r_cmd;
    logic [ise_pkg::POS_W-1:0]        r_pa;
    logic [ise_pkg::POS_W-1:0]        r_pb;
    logic [ise_pkg::CNT_W-1:0]        r_count;
    logic [ise_pkg::CNT_W-1:0]        r_ptr;
    ise_pkg::t_word                   r_res_data;
    logic [ise_pkg::FIDX_W-1:0]       r_res_fidx;
    ise_pkg::t_status                 r_res_status;
    logic                             r_out_valid;
    logic signed [ise_pkg::VALUE_W-1:0] r_out_data;
    logic [ise_pkg::FIDX_W-1:0]       r_out_fidx;
    logic [ise_pkg::STATUS_W-1:0]     r_out_status;
    logic [ise_pkg::FILL_W-1:0]       r_out_fill;

    logic [ise_pkg::CNT_W-1:0]        cnt_m1;
    logic [ise_pkg::CNT_W-1:0]        ptr_p1;
    logic [ise_pkg::POS_W-1:0]        pa_m1;
    logic [ise_pkg::POS_W-1:0]        pb_m1;
    logic [ise_pkg::IDX_W-1:0]        rd_addr;
    logic [ise_pkg::IDX_W-1:0]        wr_addr;
    ise_pkg::t_word                   wr_data;

    assign cnt_m1 = r_count - ise_pkg::CNT_W'(1);
    assign ptr_p1 = r_ptr + ise_pkg::CNT_W'(1);
    assign pa_m1  = r_pa - ise_pkg::POS_W'(1);
    assign pb_m1  = r_pb - ise_pkg::POS_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            ise_pkg::RD_TOP:  rd_addr = ise_pkg::IDX_W'(cnt_m1);
            ise_pkg::RD_PA:   rd_addr = ise_pkg::IDX_W'(pa_m1);
            ise_pkg::RD_PB:   rd_addr = ise_pkg::IDX_W'(pb_m1);
            ise_pkg::RD_PTR:  rd_addr = ise_pkg::IDX_W'(r_ptr);
            ise_pkg::RD_PTR1: rd_addr = ise_pkg::IDX_W'(ptr_p1);
            default:          rd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            ise_pkg::WR_COUNT: wr_addr = ise_pkg::IDX_W'(r_count);
            ise_pkg::WR_PA:    wr_addr = ise_pkg::IDX_W'(pa_m1);
            ise_pkg::WR_PB:    wr_addr = ise_pkg::IDX_W'(pb_m1);
            default:           wr_addr = ise_pkg::IDX_W'(r_ptr);
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            ise_pkg::WD_VAL: wr_data = r_val;
            ise_pkg::WD_RD:  wr_data = r_rd;
            default:         wr_data = r_hold;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_command;
            r_val <= ise_pkg::DATA_WIDTH'(i_value);
            r_pa  <= i_position;
            r_pb  <= i_position_b;
        end
        if (i_cmd.hold_we) r_hold <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.ptr_op)
            ise_pkg::PTR_ZERO: r_ptr <= '0;
            ise_pkg::PTR_PA:   r_ptr <= ise_pkg::CNT_W'(pa_m1);
            ise_pkg::PTR_INC:  r_ptr <= ptr_p1;
            default:           r_ptr <= r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                ise_pkg::CNT_INC: r_count <= r_count + ise_pkg::CNT_W'(1);
                ise_pkg::CNT_DEC: r_count <= cnt_m1;
                ise_pkg::CNT_CLR: r_count <= '0;
                default:          r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_res_data   <= '0;
            r_res_fidx   <= '0;
            r_res_status <= ise_pkg::ST_OK;
        end else begin
            if (i_cmd.res_data_we) r_res_data <= r_rd;
            if (i_cmd.res_fidx_we) r_res_fidx <= ise_pkg::FIDX_W'(r_ptr);
            if (i_cmd.res_status_we) r_res_status <= i_cmd.res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= ise_pkg::VALUE_W'(r_res_data);
            r_out_fidx   <= r_res_fidx;
            r_out_status <= r_res_status;
            r_out_fill   <= ise_pkg::FILL_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data        = r_out_data;
    assign o_found_index = r_out_fidx;
    assign o_status      = r_out_status;
    assign o_fill_count  = r_out_fill;

    assign o_sts.cmd         = ise_pkg::t_cmd'(r_cmd);
    assign o_sts.empty       = (r_count == '0);
    assign o_sts.full        = (r_count == ise_pkg::CNT_W'(ise_pkg::DEPTH));
    assign o_sts.pa_ok       = (r_pa != '0) &&
                               (ise_pkg::CMP_W'(r_pa) <= ise_pkg::CMP_W'(r_count));
    assign o_sts.pb_ok       = (r_pb != '0) &&
                               (ise_pkg::CMP_W'(r_pb) <= ise_pkg::CMP_W'(r_count));
    assign o_sts.ptr_lt_cnt  = (r_ptr < r_count);
    assign o_sts.ptr1_lt_cnt = (ptr_p1 < r_count);
    assign o_sts.match       = (r_rd == r_val);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// ===== design/indexed_stack_engine.sv =====
// Top level of the indexed stack engine: sequencer plus datapath.
// Depends on ise_pkg, ise_ctrl and ise_dp.
//
//   channel  handshake                  payload
//   input    i_in_valid / o_in_stall    i_command, i_value, i_position, i_position_b
//   output   o_out_valid / i_out_stall  o_data, o_found_index, o_status, o_fill_count
//
// One item at a time. Push, set, clear, unused codes and any failed check go straight to
// the response; pop, peek and get read one entry; swap reads both entries, then writes
// each; find reads and compares one entry at a time; remove_at and pop_bottom move each
// later entry down. The entry memory has one read and one write port, with registered read.
// Synchronous active-low reset empties the store at once; no clearing pass.
// A result waiting under i_out_stall holds the block in its response cycle.
`timescale 1ns / 1ps
`default_nettype none

module indexed_stack_engine (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [ise_pkg::CMD_W-1:0]          i_command,
    input  wire logic signed [ise_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ise_pkg::POS_W-1:0]          i_position,
    input  wire logic [ise_pkg::POS_W-1:0]          i_position_b,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [ise_pkg::VALUE_W-1:0]      o_data,
    output logic [ise_pkg::FIDX_W-1:0]              o_found_index,
    output logic [ise_pkg::STATUS_W-1:0]            o_status,
    output logic [ise_pkg::FILL_W-1:0]              o_fill_count
);

    ise_pkg::t_dp_cmd dp_cmd;
    ise_pkg::t_dp_sts dp_sts;

    ise_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    ise_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_position_b  (i_position_b),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_data        (o_data),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts)
    );

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> dp_sts.out_free)
        else $error("result loaded over an unaccepted result");

    a_full_means_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ise_pkg::ST_FULL)) |->
        (o_fill_count == ise_pkg::FILL_W'(ise_pkg::DEPTH)))
        else $error("full status with a store that is not full");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ise_pkg::ST_EMPTY)) |-> (o_fill_count == '0))
        else $error("empty status with entries stored");

    a_no_write_and_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_in |-> !dp_cmd.wr_en && !o_in_stall)
        else $error("item latched while the sequencer is busy");
`endif

endmodule

`default_nettype wire
